// File: rtl/i2a_pkg.sv
package i2a_pkg;

    // Field widths fixed by the stream format
    localparam int VALUE_BITS  = 64;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 6;
    localparam int CHAR_BITS   = 7;
    localparam int S_TDATA_W   = 72;   // value + radix, padded to bytes
    localparam int M_TDATA_W   = 8;    // character, padded to a byte

    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;
    localparam logic [DIGIT_BITS-1:0] DEC_BASE  = 6'd10;
    localparam logic [CHAR_BITS-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_BITS-1:0]  ASCII_LC_A = 7'h61;

    // One queued conversion job
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
    } job_t;

    function automatic logic [CHAR_BITS-1:0] digit_to_ascii(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ch;
        if (d < DEC_BASE)
        begin
            ch = ASCII_ZERO + {1'b0, d};
        end
        else
        begin
            ch = ASCII_LC_A + {1'b0, d - DEC_BASE};
        end
        return ch;
    endfunction

endpackage

// File: rtl/i2a_front.sv
module i2a_front #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [i2a_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           q_full,
    output logic                           q_push,
    output i2a_pkg::job_t                  q_job
);
    import i2a_pkg::*;

    localparam logic [VALUE_BITS-1:0] VALUE_MASK = {VALUE_BITS{1'b1}} >> (VALUE_BITS - VALUE_WIDTH);

    logic [RADIX_BITS-1:0] radix_in;
    logic [RADIX_BITS-1:0] radix_sat;

    assign radix_in = s_tdata[VALUE_BITS +: RADIX_BITS];

    // clamp radix into 2..36
    always_comb
    begin
        if (radix_in < RADIX_MIN)
        begin
            radix_sat = RADIX_MIN;
        end
        else if (radix_in > RADIX_MAX)
        begin
            radix_sat = RADIX_MAX;
        end
        else
        begin
            radix_sat = radix_in;
        end
    end

    assign s_tready    = ~q_full;
    assign q_push      = s_tvalid & ~q_full;
    assign q_job.value = s_tdata[VALUE_BITS-1:0] & VALUE_MASK;
    assign q_job.radix = radix_sat;

endmodule

// File: rtl/i2a_fifo.sv
module i2a_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  i2a_pkg::job_t  push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output i2a_pkg::job_t  head_job
);
    import i2a_pkg::*;

    // two-entry queue
    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head_job  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// File: rtl/i2a_back.sv
module i2a_back #(
    parameter int VALUE_WIDTH = 64,
    parameter int MAX_DIGITS  = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_avail,
    input  i2a_pkg::job_t                  job,
    output logic                           job_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [i2a_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import i2a_pkg::*;

    localparam int IW = $clog2(MAX_DIGITS);
    localparam int BW = $clog2(VALUE_WIDTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_DIGITS - 1);
    localparam logic [BW-1:0] LAST_BIT = BW'(VALUE_WIDTH - 1);

    typedef enum logic [2:0] {IDLE, DIV, RD, LD, HOLD} state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [DIGIT_BITS-1:0]  rem_reg;
    logic [RADIX_BITS-1:0]  radix_reg;
    logic [BW-1:0]          bit_reg;
    logic [IW-1:0]          idx_reg;
    logic                   out_valid_reg;
    logic [CHAR_BITS-1:0]   char_reg;
    logic                   last_reg;

    logic [DIGIT_BITS-1:0]  store [MAX_DIGITS];
    logic [DIGIT_BITS-1:0]  rd_data_reg;

    // one restoring division step: shift in next quotient bit
    logic [DIGIT_BITS:0]    trial;
    logic                   q_bit;
    logic [DIGIT_BITS-1:0]  rem_next;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic                   wr_en;

    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign q_bit    = (trial >= {1'b0, radix_reg});
    assign rem_next = q_bit ? DIGIT_BITS'(trial - {1'b0, radix_reg}) : trial[DIGIT_BITS-1:0];
    assign quo_next = {quo_reg[VALUE_WIDTH-2:0], q_bit};
    assign wr_en    = (state_reg == DIV) && (bit_reg == '0);

    assign job_pop  = (state_reg == IDLE) && job_avail;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CHAR_BITS){1'b0}}, char_reg};
    assign m_tlast  = last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[idx_reg] <= rem_next;
        end
        rd_data_reg <= store[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            quo_reg       <= '0;
            rem_reg       <= '0;
            radix_reg     <= RADIX_MIN;
            bit_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (job_avail)
                    begin
                        quo_reg   <= job.value[VALUE_WIDTH-1:0];
                        radix_reg <= job.radix;
                        rem_reg   <= '0;
                        bit_reg   <= LAST_BIT;
                        idx_reg   <= '0;
                        state_reg <= DIV;
                    end
                end
                DIV:
                begin
                    if (bit_reg == '0)
                    begin
                        // digit done, written to store at idx
                        if ((quo_next == '0) || (idx_reg == LAST_IDX))
                        begin
                            state_reg <= RD;
                        end
                        else
                        begin
                            quo_reg <= quo_next;
                            rem_reg <= '0;
                            bit_reg <= LAST_BIT;
                            idx_reg <= idx_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        quo_reg <= quo_next;
                        rem_reg <= rem_next;
                        bit_reg <= bit_reg - BW'(1);
                    end
                end
                RD:
                begin
                    state_reg <= LD;
                end
                LD:
                begin
                    char_reg      <= digit_to_ascii(rd_data_reg);
                    last_reg      <= (idx_reg == '0);
                    out_valid_reg <= 1'b1;
                    state_reg     <= HOLD;
                end
                HOLD:
                begin
                    if (m_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (idx_reg == '0)
                        begin
                            state_reg <= IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg - IW'(1);
                            state_reg <= RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    a_valid_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg == (state_reg == HOLD))
        else $error("output valid outside HOLD");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DIV) |-> (rem_reg < radix_reg))
        else $error("partial remainder not below radix");

    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != IDLE) |-> (radix_reg >= RADIX_MIN && radix_reg <= RADIX_MAX))
        else $error("radix out of range in conversion");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && m_tready && last_reg) |=> (state_reg == IDLE))
        else $error("run did not end after last character");

endmodule

// File: rtl/integer_to_ascii_radix.sv
// Channel  | Dir | Signals                     | Item
// ---------+-----+-----------------------------+------------------------------------
// s (in)   | in  | s_tvalid s_tready s_tdata   | value[63:0], radix[69:64], pad 0
// m (out)  | out | m_tvalid m_tready m_tdata   | character[6:0], pad 0; m_tlast=last
//
// Per item, the bit-serial divider retires one quotient bit per cycle for each digit,
// and each character then takes a store read (RD), an output load (LD) and a
// handshake (HOLD) that waits for m_tready.
// Reset (rst_n low, asynchronous) empties the two-entry job queue and idles the back end.
// Input keeps flowing into the queue while a conversion runs or a character stalls;
// s_tready drops only when both queue entries are held.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = 64,   // low bits of value that are converted, 8..64
    parameter int MAX_DIGITS  = 64    // digit store depth, 8..64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [i2a_pkg::S_TDATA_W-1:0]  s_tdata,   // value[63:0], radix[69:64]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [i2a_pkg::M_TDATA_W-1:0]  m_tdata,   // character[6:0]
    output logic                           m_tlast
);
    import i2a_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_avail;
    job_t push_job;
    job_t head_job;

    // front: clamp radix, mask value, push into queue
    i2a_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    // short job queue decoupling input from conversion
    i2a_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_avail),
        .head_job  (head_job)
    );

    // back: serial divide into digit store, then emit most significant first
    i2a_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_avail (q_avail),
        .job       (head_job),
        .job_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Checks integer_to_ascii_radix over its two stream ports.
// Items queued by the stimulus block are fed by a falling-edge driver; accepted
// items are converted here into the expected character runs, and every character
// coming out is compared, oldest first, at the rising edge.
module tb_top;
    import i2a_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;   // cycles with no item moving on either side
    localparam int DRAIN_CYCLES   = 300;     // settle time after the last character
    localparam int PHASE_ITEMS    = 110;     // items per idling phase

    localparam logic [CHAR_BITS-1:0]  CHAR_ZERO  = 7'h30;   // '0'
    localparam logic [CHAR_BITS-1:0]  CHAR_LC_A  = 7'h61;   // 'a'
    localparam logic [DIGIT_BITS-1:0] DECIMAL    = 6'd10;
    localparam logic [RADIX_BITS-1:0] BASE_LOW   = 6'd2;
    localparam logic [RADIX_BITS-1:0] BASE_HIGH  = 6'd36;

    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic [RADIX_BITS-1:0] radix;
        bit                    drain_first;   // hold off until all text is out
    } conv_req_t;

    typedef struct {
        logic [CHAR_BITS-1:0] character;
        logic                 last;
    } text_char_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    conv_req_t  pending_reqs[$];
    text_char_t expected_text[$];

    int  items_sent = 0;
    int  mismatches = 0;
    int  stall_count = 0;
    bit  item_taken = 0;   // set at posedge when the driver's item went in

    integer_to_ascii_radix uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Idle percentages by phase: sender light / receiver heavy, then swapped, then none.
    function automatic int sender_idle_pct(int sent);
        if (sent < PHASE_ITEMS)
        begin
            return 15;
        end
        if (sent < 2 * PHASE_ITEMS)
        begin
            return 46;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int sent);
        if (sent < PHASE_ITEMS)
        begin
            return 46;
        end
        if (sent < 2 * PHASE_ITEMS)
        begin
            return 15;
        end
        return 0;
    endfunction

    function automatic bit roll(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // Expected text for one number: clamp the base, peel off remainders,
    // then queue the digits most significant first with last on the final one.
    function automatic void convert_to_text(logic [VALUE_BITS-1:0] value,
                                            logic [RADIX_BITS-1:0] radix);
        logic [RADIX_BITS-1:0] base;
        logic [VALUE_BITS-1:0] quot;
        logic [DIGIT_BITS-1:0] digits [0:63];
        logic [DIGIT_BITS-1:0] d;
        text_char_t            tc;
        int                    n;
        base = radix;
        if (base < BASE_LOW)
        begin
            base = BASE_LOW;
        end
        if (base > BASE_HIGH)
        begin
            base = BASE_HIGH;
        end
        quot = value;
        n = 0;
        do
        begin
            digits[n] = DIGIT_BITS'(quot % base);
            n++;
            quot = quot / base;
        end
        while (quot != 0 && n < 64);
        for (int k = n - 1; k >= 0; k--)
        begin
            d = digits[k];
            if (d < DECIMAL)
            begin
                tc.character = CHAR_ZERO + {1'b0, d};
            end
            else
            begin
                tc.character = CHAR_LC_A + {1'b0, d - DECIMAL};
            end
            tc.last = (k == 0);
            expected_text.push_back(tc);
        end
    endfunction

    function automatic void queue_req(logic [VALUE_BITS-1:0] value,
                                      logic [RADIX_BITS-1:0] radix, bit drain_first);
        conv_req_t r;
        r.value = value;
        r.radix = radix;
        r.drain_first = drain_first;
        pending_reqs.push_back(r);
    endfunction

    // Driver: present a new item once the previous one is taken (or none is up).
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= !roll(receiver_idle_pct(items_sent));
            if (!s_tvalid || item_taken)
            begin
                item_taken = 0;
                if (pending_reqs.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs[0].drain_first && expected_text.size() != 0)
                begin
                    s_tvalid <= 1'b0;   // pause until every character is out
                end
                else if (roll(sender_idle_pct(items_sent)))
                begin
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    conv_req_t r;
                    r = pending_reqs.pop_front();
                    s_tdata  <= {2'b00, r.radix, r.value};
                    s_tvalid <= 1'b1;
                end
            end
        end
    end

    // Monitor: predict on accepted input, check accepted output, watch for hangs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            bit moved;
            moved = 0;
            if (s_tvalid && s_tready)
            begin
                convert_to_text(s_tdata[VALUE_BITS-1:0],
                                s_tdata[VALUE_BITS +: RADIX_BITS]);
                items_sent++;
                item_taken = 1;
                moved = 1;
            end
            if (m_tvalid && m_tready)
            begin
                moved = 1;
                if (expected_text.size() == 0)
                begin
                    $error("unexpected character %0h (last %0b)", m_tdata[CHAR_BITS-1:0],
                           m_tlast);
                    mismatches++;
                end
                else
                begin
                    text_char_t exp_c;
                    exp_c = expected_text.pop_front();
                    if (m_tdata[CHAR_BITS-1:0] !== exp_c.character)
                    begin
                        $error("character: expected %0h, got %0h", exp_c.character,
                               m_tdata[CHAR_BITS-1:0]);
                        mismatches++;
                    end
                    if (m_tlast !== exp_c.last)
                    begin
                        $error("last: expected %0b, got %0b", exp_c.last, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (moved)
            begin
                stall_count = 0;
            end
            else
            begin
                stall_count++;
                if (stall_count >= WATCHDOG_LIMIT)
                begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        logic [VALUE_BITS-1:0] raw;
        logic [RADIX_BITS-1:0] rad;
        int                    bits;
        int                    pick;

        // Directed: zero, extremes of value and base, clamped bases, digit edges.
        queue_req(64'd0, 6'd10, 0);
        queue_req(64'd0, 6'd0, 0);                      // zero with base raised to 2
        queue_req(64'd0, 6'd63, 0);                     // zero with base capped
        queue_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd2, 0);    // longest run: 64 digits
        queue_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd36, 0);
        queue_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 0);
        queue_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 0);   // base above range
        queue_req(64'h0123_4567_89AB_CDEF, 6'd16, 0);
        queue_req(64'd1, 6'd2, 0);
        queue_req(64'd5, 6'd0, 0);                      // base below range
        queue_req(64'd5, 6'd1, 0);
        queue_req(64'd1000, 6'd37, 0);
        queue_req(64'd35, 6'd36, 0);                    // single 'z'
        queue_req(64'd36, 6'd36, 0);                    // "10"
        queue_req(64'd9, 6'd10, 0);
        queue_req(64'd10, 6'd11, 0);                    // single 'a'
        queue_req(64'h8000_0000_0000_0000, 6'd8, 0);
        queue_req(64'h5555_5555_5555_5555, 6'd21, 0);
        queue_req(64'hAAAA_AAAA_AAAA_AAAA, 6'd42, 0);
        queue_req(64'd12345, 6'd3, 0);

        // Random part: numbers of random bit length, bases mostly in range.
        for (int i = 0; i < 310; i++)
        begin
            bits = $urandom_range(64, 0);
            raw  = {$urandom, $urandom};
            if ($urandom_range(19, 0) == 0)
            begin
                raw = '1;
            end
            if (bits == 0)
            begin
                raw = '0;
            end
            else
            begin
                raw = raw >> (64 - bits);
            end
            pick = $urandom_range(9, 0);
            if (pick == 0)
            begin
                rad = RADIX_BITS'($urandom_range(1, 0));
            end
            else if (pick == 1)
            begin
                rad = RADIX_BITS'($urandom_range(63, 37));
            end
            else
            begin
                rad = RADIX_BITS'($urandom_range(36, 2));
            end
            queue_req(raw, rad, (i == 0) || (i == 90) || (i == 200));
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_text.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/i2a_pkg.sv
rtl/i2a_front.sv
rtl/i2a_fifo.sv
rtl/i2a_back.sv
rtl/integer_to_ascii_radix.sv
tb/tb_top.sv
